[src/ura_pkg.sv]
package ura_pkg;

  localparam int CNT_W = 4;
  localparam int CHAR_W = 7;

  localparam logic [1:0] KIND_DEC = 2'd0;
  localparam logic [1:0] KIND_HEX_UPPER = 2'd1;
  localparam logic [1:0] KIND_HEX_LOWER = 2'd2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } ura_state_t;

  typedef struct packed {
    logic load;
    logic hex;
    logic step;
  } ura_op_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic             lower;
    logic [CNT_W-1:0] count;
  } ura_emit_t;

  // decimal digits needed for the largest value of the given width
  function automatic int dec_digits(int bits);
    longint unsigned m;
    int n;
    m = (bits >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << bits) - 64'd1);
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (m != 64'd0) begin
        n = n + 1;
        m = m / 64'd10;
      end
    end
    return (n == 0) ? 1 : n;
  endfunction

endpackage

[src/ura_dabble.sv]
module ura_dabble
  import ura_pkg::*;
#(
  parameter int W = 32,
  parameter int ND = 10,
  parameter int IW = 4
) (
  input  logic          clk,
  input  ura_op_t       op,
  input  logic [W-1:0]  value_in,
  input  logic [IW-1:0] rd_idx,
  output logic [3:0]    rd_digit
);

  localparam int BW = ND * 4;

  logic [BW-1:0] bcd;
  logic [W-1:0]  bin;
  logic [BW-1:0] adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op.load) begin
      if (op.hex) begin
        bcd <= BW'(value_in);
        bin <= '0;
      end else begin
        bcd <= '0;
        bin <= value_in;
      end
    end else if (op.step) begin
      {bcd, bin} <= {adj[BW-2:0], bin, 1'b0};
    end
  end

  assign rd_digit = bcd[rd_idx*4 +: 4];

endmodule

[src/ura_ctrl.sv]
module ura_ctrl
  import ura_pkg::*;
#(
  parameter int W = 32,
  parameter int ND = 10,
  parameter int IW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    kind,
  input  logic          out_free,
  input  logic [3:0]    rd_digit,
  output ura_op_t       op,
  output logic [IW-1:0] rd_idx,
  output ura_emit_t     emit
);

  localparam int SW = (W > 1) ? $clog2(W) : 1;

  ura_state_t       state, state_next;
  logic [IW-1:0]    idx, idx_next;
  logic [SW-1:0]    step_cnt, step_cnt_next;
  logic             lower, lower_next;
  logic [CNT_W-1:0] count, count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    idx      <= idx_next;
    step_cnt <= step_cnt_next;
    lower    <= lower_next;
    count    <= count_next;
  end

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    step_cnt_next = step_cnt;
    lower_next    = lower;
    count_next    = count;
    in_ready      = 1'b0;
    op            = '0;
    emit          = '0;
    emit.last     = (idx == '0);
    emit.lower    = lower;
    emit.count    = (idx == '0) ? count : '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op.load       = 1'b1;
          op.hex        = (kind != KIND_DEC);
          lower_next    = kind[1];
          step_cnt_next = '0;
          idx_next      = IW'(ND - 1);
          state_next    = (kind != KIND_DEC) ? ST_SKIP : ST_CONV;
        end
      end
      ST_CONV: begin
        op.step       = 1'b1;
        step_cnt_next = step_cnt + SW'(1);
        if (step_cnt == SW'(W - 1)) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (rd_digit == 4'd0 && idx != '0) begin
          idx_next = idx - IW'(1);
        end else begin
          count_next = CNT_W'({1'b0, idx} + (IW + 1)'(1));
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        emit.valid = out_free;
        if (out_free) begin
          if (idx == '0) begin
            state_next = ST_IDLE;
          end else begin
            idx_next = idx - IW'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign rd_idx = idx;

endmodule

[src/unsigned_radix_to_ascii_unit.sv]
// Unsigned number to ASCII digit stream.
// Input channel s_*: one transfer carries a 32-bit value in s_tdata and a kind in
// s_tuser (0 decimal, 1 upper-case hex, 2 or 3 lower-case hex). Only the low
// VALUE_BITS bits of the value are used.
// Output channel m_*: one transfer per character, most significant digit first,
// leading zeros dropped, zero gives a single '0'. m_tlast marks the final
// character, which also carries the character count; other counts are zero.
// Timing: the input is taken only when the unit is idle. Decimal runs one
// shift-and-adjust step per value bit, hex loads directly. A leading zero scan
// then steps past each suppressed digit, and characters leave at one per cycle
// while the receiver keeps up. The single digit register and its step unit mean
// a new value is taken only once the last character has entered the output
// register.
// A stalled receiver holds the output register and the emit sequence waits;
// nothing is dropped. A new value may be taken while the last character waits.
// Reset returns the sequencer to idle and empties the output register.
module unsigned_radix_to_ascii_unit
  import ura_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value
  input  logic [1:0]  s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // digit_char[6:0], digit_count[10:7], zero fill
  output logic        m_tlast    // last_digit
);

  localparam int W = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int ND_DEC = dec_digits(W);
  localparam int ND_HEX = (W + 3) / 4;
  localparam int ND = (ND_DEC > ND_HEX) ? ND_DEC : ND_HEX;
  localparam int IW = (ND > 1) ? $clog2(ND) : 1;

  ura_op_t          op;
  ura_emit_t        emit;
  logic [IW-1:0]    rd_idx;
  logic [3:0]       rd_digit;
  logic             out_free;
  logic [CHAR_W-1:0] char_code;
  logic [CHAR_W-1:0] out_char;
  logic [CNT_W-1:0]  out_count;

  ura_ctrl #(.W(W), .ND(ND), .IW(IW)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .kind     (s_tuser),
    .out_free (out_free),
    .rd_digit (rd_digit),
    .op       (op),
    .rd_idx   (rd_idx),
    .emit     (emit)
  );

  ura_dabble #(.W(W), .ND(ND), .IW(IW)) u_dabble (
    .clk      (clk),
    .op       (op),
    .value_in (s_tdata[W-1:0]),
    .rd_idx   (rd_idx),
    .rd_digit (rd_digit)
  );

  always_comb begin
    if (rd_digit < 4'd10) begin
      char_code = ASCII_ZERO + CHAR_W'(rd_digit);
    end else if (emit.lower) begin
      char_code = ASCII_LOWER_A + CHAR_W'(rd_digit) - CHAR_W'(10);
    end else begin
      char_code = ASCII_UPPER_A + CHAR_W'(rd_digit) - CHAR_W'(10);
    end
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= emit.valid;
    end
    if (emit.valid) begin
      out_char  <= char_code;
      out_count <= emit.count;
      m_tlast   <= emit.last;
    end
  end

  assign m_tdata = {5'd0, out_count, out_char};

  a_last_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> out_count != '0)
    else $error("last character without a count");

  a_mid_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> out_count == '0)
    else $error("count on a character that is not last");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_char >= ASCII_ZERO)
    else $error("character below ASCII zero");

  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> !s_tready)
    else $error("input taken while emitting");

endmodule

[sim/tb_top.sv]
module tb_top;
  import ura_pkg::*;

  localparam int VALUE_BITS = 32;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RAND_PER_PHASE = 72;
  localparam int N_PHASES = 4;
  // unused kind code, decoded as lower-case hex
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam logic [31:0] POW10 [10] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
    32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
  };

  localparam int SEND_IDLE_PCT [N_PHASES] = '{0, 79, 0, 9};
  localparam int RECV_STALL_PCT [N_PHASES] = '{0, 0, 79, 9};

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] value;
  } conv_req_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic [CNT_W-1:0]  count;
  } digit_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  conv_req_t conv_q[$];
  digit_t    digit_q[$];
  conv_req_t next_req;
  digit_t    got;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int n_queued = 0;
  int n_values = 0;
  int n_chars = 0;
  int n_errs = 0;
  int idle_cycles = 0;

  unsigned_radix_to_ascii_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic note_error(input string msg);
    n_errs++;
    if (n_errs <= 10) $display("ERROR: %s", msg);
  endtask

  // digits of one value, most significant first, queued as expected transfers
  task automatic expand_digits(input logic [1:0] kind, input logic [31:0] value);
    logic [CHAR_W-1:0] chars[$];
    logic [31:0] v;
    logic [31:0] mask;
    logic [3:0] d;
    digit_t e;
    mask = (VALUE_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << VALUE_BITS) - 32'd1);
    v = value & mask;
    do begin
      if (kind == KIND_DEC) begin
        d = 4'(v % 32'd10);
        v = v / 32'd10;
      end else begin
        d = v[3:0];
        v = v >> 4;
      end
      if (d < 4'd10) chars.push_front(ASCII_ZERO + CHAR_W'(d));
      else if (kind[1]) chars.push_front(ASCII_LOWER_A + CHAR_W'(d - 4'd10));
      else chars.push_front(ASCII_UPPER_A + CHAR_W'(d - 4'd10));
    end while (v != 0);
    for (int k = 0; k < chars.size(); k++) begin
      e.ch = chars[k];
      e.last = (k == chars.size() - 1);
      e.count = e.last ? CNT_W'(chars.size()) : '0;
      digit_q.push_back(e);
    end
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0: pick_value = r >> $urandom_range(0, 31);
      1: pick_value = $urandom_range(0, 20);
      2: pick_value = POW10[$urandom_range(0, 9)] - $urandom_range(0, 1);
      3: pick_value = r | 32'hF000_0000;
      default: pick_value = r;
    endcase
  endfunction

  task automatic queue_req(input logic [1:0] kind, input logic [31:0] value);
    conv_req_t q;
    q.kind = kind;
    q.value = value;
    conv_q.push_back(q);
    n_queued++;
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (conv_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_req = conv_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= next_req.value;
        s_tuser <= next_req.kind;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // prediction and checking
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expand_digits(s_tuser, s_tdata);
        n_values++;
      end
      if (m_tvalid && m_tready) begin
        n_chars++;
        if (digit_q.size() == 0) begin
          note_error($sformatf("unexpected transfer char=%h last=%b count=%0d",
                               m_tdata[6:0], m_tlast, m_tdata[10:7]));
        end else begin
          got = digit_q.pop_front();
          if (got.ch !== m_tdata[6:0] || got.last !== m_tlast ||
              got.count !== m_tdata[10:7])
            note_error($sformatf(
              "char exp %h got %h, last exp %b got %b, count exp %0d got %0d",
              got.ch, m_tdata[6:0], got.last, m_tlast, got.count, m_tdata[10:7]));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    queue_req(KIND_DEC, 32'd0);
    queue_req(KIND_HEX_UPPER, 32'd0);
    queue_req(KIND_HEX_LOWER, 32'd0);
    queue_req(KIND_SPARE, 32'd0);
    queue_req(KIND_DEC, 32'hFFFF_FFFF);
    queue_req(KIND_HEX_UPPER, 32'hFFFF_FFFF);
    queue_req(KIND_HEX_LOWER, 32'hFFFF_FFFF);
    queue_req(KIND_SPARE, 32'hFFFF_FFFF);
    queue_req(KIND_DEC, 32'd1);
    queue_req(KIND_DEC, 32'd9);
    queue_req(KIND_DEC, 32'd10);
    queue_req(KIND_DEC, 32'd999999999);
    queue_req(KIND_DEC, 32'd1000000000);
    queue_req(KIND_DEC, 32'h8000_0000);
    queue_req(KIND_HEX_UPPER, 32'hDEAD_BEEF);
    queue_req(KIND_HEX_LOWER, 32'hDEAD_BEEF);
    queue_req(KIND_SPARE, 32'hABCD_EF01);
    queue_req(KIND_HEX_UPPER, 32'h0000_000F);
    queue_req(KIND_HEX_LOWER, 32'h0000_0010);
    queue_req(KIND_HEX_UPPER, 32'h8000_0000);
    queue_req(KIND_HEX_LOWER, 32'h1234_5678);

    for (int p = 0; p < N_PHASES; p++) begin
      send_idle_pct = SEND_IDLE_PCT[p];
      recv_stall_pct = RECV_STALL_PCT[p];
      for (int i = 0; i < RAND_PER_PHASE; i++)
        queue_req(2'($urandom_range(0, 3)), pick_value());
      while (n_values != n_queued || digit_q.size() != 0) @(posedge clk);
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (digit_q.size() != 0)
      note_error($sformatf("%0d expected characters never arrived", digit_q.size()));

    $display("converted %0d values (decimal, upper and lower hex, spare kind)", n_values);
    $display("checked %0d characters over four handshake pressure phases, %0d errors",
             n_chars, n_errs);
    if (n_errs == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
